>>> sv/btc_pkg.sv
package btc_pkg;

	// Configuration register indexes
	localparam int CfgIdxW = 8;
	localparam logic [CfgIdxW-1:0] CFG_TEMP_TRIM = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_PRES_TRIM_A = 8'd1;
	localparam logic [CfgIdxW-1:0] CFG_PRES_TRIM_B = 8'd2;
	localparam logic [CfgIdxW-1:0] CFG_PRES_TRIM_C = 8'd3;

	// Queue between front and back
	localparam int MidDepth = 4;
	localparam int MidPtrW = 2;

	// Restoring divider, one quotient bit per stage
	localparam int DivSteps = 64;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} btc_in_t;

	typedef struct packed {
		logic signed [31:0] fine_temperature;
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               divide_by_zero;
	} btc_out_t;

	// Word handed from front to back
	typedef struct packed {
		logic signed [31:0] tf;
		logic signed [31:0] tc;
		logic [63:0]        num;
		logic [63:0]        den;
	} btc_mid_t;

	typedef struct packed {
		logic [47:0] temp_trim;
		logic [63:0] pres_trim_a;
		logic [63:0] pres_trim_b;
		logic [15:0] pres_trim_c;
	} btc_trim_t;

endpackage

>>> sv/btc_queue.sv
module btc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  btc_pkg::btc_mid_t wr_data,
	output logic             full,
	input  logic             pop,
	output btc_pkg::btc_mid_t rd_data,
	output logic             empty
);

	btc_pkg::btc_mid_t mem_q [0:btc_pkg::MidDepth-1];
	logic [btc_pkg::MidPtrW-1:0] wr_ptr_q;
	logic [btc_pkg::MidPtrW-1:0] rd_ptr_q;
	logic [btc_pkg::MidPtrW:0]   cnt_q;
	logic do_push;
	logic do_pop;

	assign full    = (cnt_q == (btc_pkg::MidPtrW+1)'(btc_pkg::MidDepth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> sv/btc_front.sv
module btc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  btc_pkg::btc_trim_t trim,
	input  logic               in_valid,
	output logic               in_ready,
	input  btc_pkg::btc_in_t   in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output btc_pkg::btc_mid_t  out_item
);

	logic [15:0] t1;
	logic [15:0] p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

	assign t1 = trim.temp_trim[15:0];
	assign t2 = $signed(trim.temp_trim[31:16]);
	assign t3 = $signed(trim.temp_trim[47:32]);
	assign p1 = trim.pres_trim_a[15:0];
	assign p2 = $signed(trim.pres_trim_a[31:16]);
	assign p3 = $signed(trim.pres_trim_a[47:32]);
	assign p4 = $signed(trim.pres_trim_a[63:48]);
	assign p5 = $signed(trim.pres_trim_b[15:0]);
	assign p6 = $signed(trim.pres_trim_b[31:16]);

	logic en;
	logic vld_q [1:10];

	// Advance the whole pipe unless the last word is blocked
	assign en        = !(vld_q[10] && !out_ready);
	assign in_ready  = en;
	assign out_valid = vld_q[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 10; k++)
				vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= in_valid;
			for (int k = 2; k <= 10; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	logic [31:0] a_s1, b_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8;
	logic [31:0] m1_s2, bb_s2;
	logic signed [31:0] tv1_s3, m2_s3;
	logic signed [31:0] tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9, tf_s10;
	logic signed [31:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic signed [32:0] v1_s5;
	logic [63:0] vsq_s6;
	logic signed [48:0] v1p5_s6, v1p2_s6, v1p5_s7, v1p2_s7;
	logic [63:0] a2_s7;
	logic signed [63:0] b3_s7;
	logic [63:0] v2_s8;
	logic signed [63:0] x_s8;
	logic signed [63:0] m_s9;
	logic [63:0] n0_s9;
	logic [63:0] num_s10, den_s10;

	logic signed [47:0] m1_c, m2_c;
	logic [31:0] bb_c;
	logic signed [31:0] tf_c, tc5_c;
	logic signed [65:0] vsq_c;
	logic signed [48:0] v1p5_c, v1p2_c;
	logic signed [79:0] a2_c, b3_c;
	logic signed [63:0] v2_c, x_c;
	logic signed [80:0] m_c;
	logic [20:0] pd_c;
	logic [63:0] n0_c;

	// Temperature terms, then pressure coefficients, the dividend and the divisor product
	always_comb begin
		m1_c   = $signed(a_s1) * t2;
		bb_c   = b_s1 * b_s1;
		m2_c   = ($signed(bb_s2) >>> 12) * t3;
		tf_c   = tv1_s3 + (m2_s3 >>> 14);
		tc5_c  = tf_s4 * 32'sd5 + 32'sd128;
		vsq_c  = v1_s5 * v1_s5;
		v1p5_c = v1_s5 * p5;
		v1p2_c = v1_s5 * p2;
		a2_c   = $signed(vsq_s6) * p6;
		b3_c   = $signed(vsq_s6) * p3;
		v2_c   = $signed(a2_s7) + (64'(v1p5_s7) <<< 17) + (64'(p4) <<< 35);
		x_c    = 64'sh0000_8000_0000_0000 + (b3_s7 >>> 8) + (64'(v1p2_s7) <<< 12);
		m_c    = x_s8 * $signed({1'b0, p1});
		pd_c   = 21'h10_0000 - {1'b0, rp_s8};
		n0_c   = ({43'b0, pd_c} << 31) - v2_s8;
	end

	// Hold stage registers while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= {15'b0, in_item.raw_temperature[19:3]} - {15'b0, t1, 1'b0};
			b_s1    <= {16'b0, in_item.raw_temperature[19:4]} - {16'b0, t1};
			rp_s1   <= in_item.raw_pressure;

			m1_s2   <= m1_c[31:0];
			bb_s2   <= bb_c;
			rp_s2   <= rp_s1;

			tv1_s3  <= $signed(m1_s2) >>> 11;
			m2_s3   <= m2_c[31:0];
			rp_s3   <= rp_s2;

			tf_s4   <= tf_c;
			rp_s4   <= rp_s3;

			tf_s5   <= tf_s4;
			tc_s5   <= tc5_c >>> 8;
			v1_s5   <= {tf_s4[31], tf_s4} - 33'sd128000;
			rp_s5   <= rp_s4;

			tf_s6   <= tf_s5;
			tc_s6   <= tc_s5;
			vsq_s6  <= vsq_c[63:0];
			v1p5_s6 <= v1p5_c;
			v1p2_s6 <= v1p2_c;
			rp_s6   <= rp_s5;

			tf_s7   <= tf_s6;
			tc_s7   <= tc_s6;
			a2_s7   <= a2_c[63:0];
			b3_s7   <= b3_c[63:0];
			v1p5_s7 <= v1p5_s6;
			v1p2_s7 <= v1p2_s6;
			rp_s7   <= rp_s6;

			tf_s8   <= tf_s7;
			tc_s8   <= tc_s7;
			v2_s8   <= v2_c;
			x_s8    <= x_c;
			rp_s8   <= rp_s7;

			tf_s9   <= tf_s8;
			tc_s9   <= tc_s8;
			m_s9    <= m_c[63:0];
			n0_s9   <= n0_c;

			tf_s10  <= tf_s9;
			tc_s10  <= tc_s9;
			num_s10 <= n0_s9 * 64'd3125;
			den_s10 <= m_s9 >>> 33;
		end
	end

	always_comb begin
		out_item.tf  = tf_s10;
		out_item.tc  = tc_s10;
		out_item.num = num_s10;
		out_item.den = den_s10;
	end

endmodule

>>> sv/btc_back.sv
module btc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  btc_pkg::btc_trim_t trim,
	input  logic               in_valid,
	output logic               in_ready,
	input  btc_pkg::btc_mid_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output btc_pkg::btc_out_t  out_item
);

	localparam int N = btc_pkg::DivSteps;

	logic signed [15:0] p7, p8, p9;

	assign p7 = $signed(trim.pres_trim_b[47:32]);
	assign p8 = $signed(trim.pres_trim_b[63:48]);
	assign p9 = $signed(trim.pres_trim_c);

	logic en;
	logic dv_q [0:N];
	logic pv_q [1:6];

	// Advance the whole pipe unless the last word is blocked
	assign en        = !(pv_q[6] && !out_ready);
	assign in_ready  = en;
	assign out_valid = pv_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++)
				dv_q[k] <= 1'b0;
			for (int k = 1; k <= 6; k++)
				pv_q[k] <= 1'b0;
		end else if (en) begin
			dv_q[0] <= in_valid;
			for (int k = 1; k <= N; k++)
				dv_q[k] <= dv_q[k-1];
			pv_q[1] <= dv_q[N];
			for (int k = 2; k <= 6; k++)
				pv_q[k] <= pv_q[k-1];
		end
	end

	// Divider stages: remainder, dividend/quotient shift word, divisor
	logic [63:0] dv_rem_s [0:N];
	logic [63:0] dv_nq_s  [0:N];
	logic [63:0] dv_ad_s  [0:N];
	logic        dv_neg_s [0:N];
	logic        dv_dz_s  [0:N];
	logic signed [31:0] dv_tf_s [0:N];
	logic signed [31:0] dv_tc_s [0:N];

	logic [63:0] rem_n [1:N];
	logic [63:0] nq_n  [1:N];
	logic [64:0] r65;
	logic [64:0] diff;
	logic        ge;

	// One quotient bit per stage
	always_comb begin
		r65  = '0;
		diff = '0;
		ge   = 1'b0;
		for (int k = 1; k <= N; k++) begin
			r65      = {dv_rem_s[k-1], dv_nq_s[k-1][63]};
			diff     = r65 - {1'b0, dv_ad_s[k-1]};
			ge       = (r65 >= {1'b0, dv_ad_s[k-1]});
			rem_n[k] = ge ? diff[63:0] : r65[63:0];
			nq_n[k]  = {dv_nq_s[k-1][62:0], ge};
		end
	end

	logic nn, dn;
	assign nn = in_item.num[63];
	assign dn = in_item.den[63];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= '0;
			dv_nq_s[0]  <= nn ? (64'd0 - in_item.num) : in_item.num;
			dv_ad_s[0]  <= dn ? (64'd0 - in_item.den) : in_item.den;
			dv_neg_s[0] <= nn ^ dn;
			dv_dz_s[0]  <= (in_item.den == 64'd0);
			dv_tf_s[0]  <= in_item.tf;
			dv_tc_s[0]  <= in_item.tc;
			for (int k = 1; k <= N; k++) begin
				dv_rem_s[k] <= rem_n[k];
				dv_nq_s[k]  <= nq_n[k];
				dv_ad_s[k]  <= dv_ad_s[k-1];
				dv_neg_s[k] <= dv_neg_s[k-1];
				dv_dz_s[k]  <= dv_dz_s[k-1];
				dv_tf_s[k]  <= dv_tf_s[k-1];
				dv_tc_s[k]  <= dv_tc_s[k-1];
			end
		end
	end

	// Pressure correction after the quotient
	logic signed [63:0] p_s1, p_s2, p_s3, p_s4, sum1_s5, w1_s5;
	logic signed [63:0] ps_s2, w2m_s2, w2_s3, w2_s4;
	logic [63:0] t_s2;
	logic [63:0] pp0_s3, s0_s4;
	logic [31:0] pp1_s3, thi_s3, pslo_s3, pp2_s4;
	logic [31:0] pres_s6;
	logic dz_s1, dz_s2, dz_s3, dz_s4, dz_s5, dz_s6;
	logic signed [31:0] tf_s1, tf_s2, tf_s3, tf_s4, tf_s5, tf_s6;
	logic signed [31:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6;

	logic signed [63:0] ps_c;
	logic signed [79:0] t_c, w2m_c;
	logic [63:0] pp0_c;
	logic [31:0] pp1_c, pp2_c;
	logic [63:0] w1sum_c;
	logic signed [63:0] pr_c;

	always_comb begin
		ps_c    = p_s1 >>> 13;
		t_c     = ps_c * p9;
		w2m_c   = p_s1 * p8;
		pp0_c   = t_s2[31:0] * ps_s2[31:0];
		pp1_c   = t_s2[31:0] * ps_s2[63:32];
		pp2_c   = thi_s3 * pslo_s3;
		w1sum_c = s0_s4 + {pp2_s4, 32'b0};
		pr_c    = ((sum1_s5 + w1_s5) >>> 8) + (64'(p7) <<< 4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= dv_neg_s[N] ? $signed(64'd0 - dv_nq_s[N]) : $signed(dv_nq_s[N]);
			dz_s1   <= dv_dz_s[N];
			tf_s1   <= dv_tf_s[N];
			tc_s1   <= dv_tc_s[N];

			p_s2    <= p_s1;
			ps_s2   <= ps_c;
			t_s2    <= t_c[63:0];
			w2m_s2  <= w2m_c[63:0];
			dz_s2   <= dz_s1;
			tf_s2   <= tf_s1;
			tc_s2   <= tc_s1;

			p_s3    <= p_s2;
			pp0_s3  <= pp0_c;
			pp1_s3  <= pp1_c;
			thi_s3  <= t_s2[63:32];
			pslo_s3 <= ps_s2[31:0];
			w2_s3   <= w2m_s2 >>> 19;
			dz_s3   <= dz_s2;
			tf_s3   <= tf_s2;
			tc_s3   <= tc_s2;

			p_s4    <= p_s3;
			pp2_s4  <= pp2_c;
			s0_s4   <= pp0_s3 + {pp1_s3, 32'b0};
			w2_s4   <= w2_s3;
			dz_s4   <= dz_s3;
			tf_s4   <= tf_s3;
			tc_s4   <= tc_s3;

			w1_s5   <= $signed(w1sum_c) >>> 25;
			sum1_s5 <= p_s4 + w2_s4;
			dz_s5   <= dz_s4;
			tf_s5   <= tf_s4;
			tc_s5   <= tc_s4;

			pres_s6 <= dz_s5 ? 32'd0 : pr_c[31:0];
			dz_s6   <= dz_s5;
			tf_s6   <= tf_s5;
			tc_s6   <= tc_s5;
		end
	end

	always_comb begin
		out_item.fine_temperature  = tf_s6;
		out_item.temperature_centi = tc_s6;
		out_item.pressure_q24_8    = pres_s6;
		out_item.divide_by_zero    = dz_s6;
	end

endmodule

>>> sv/barometer_trim_compensation.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------
// input     push, full, in_data (btc_in_t)          word taken: push && !full
// result    empty, pop, out_data (btc_out_t)        word taken: pop && !empty
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  write: cfg_valid && cfg_ready
//
// One word per cycle sustained while the result side keeps up; a word taken on in_data
// passes through the front stages, the middle queue, 65 divider stages (the operand
// stage plus 64 quotient bits), 6 correction stages and the result queue before it
// shows on out_data.
// Reset clears all trim registers to zero and empties both queues.
// A stalled result stalls only the back pipe; the front keeps filling the
// middle queue and raises full once that queue is full and a word waits at
// the end of the front pipe.
module barometer_trim_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  btc_pkg::btc_in_t              in_data,
	output logic                          empty,
	input  logic                          pop,
	output btc_pkg::btc_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [btc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                   cfg_data
);

	btc_pkg::btc_trim_t trim_q;

	assign cfg_ready = 1'b1;

	// Write trim registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				btc_pkg::CFG_TEMP_TRIM:   trim_q.temp_trim   <= cfg_data[47:0];
				btc_pkg::CFG_PRES_TRIM_A: trim_q.pres_trim_a <= cfg_data;
				btc_pkg::CFG_PRES_TRIM_B: trim_q.pres_trim_b <= cfg_data;
				btc_pkg::CFG_PRES_TRIM_C: trim_q.pres_trim_c <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic in_ready;
	logic front_valid, mid_full, mid_empty, back_ready, back_valid, oq_ready;
	btc_pkg::btc_mid_t front_word, mid_word;
	btc_pkg::btc_out_t back_word;

	assign full = !in_ready;

	btc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.trim      (trim_q),
		.in_valid  (push),
		.in_ready  (in_ready),
		.in_item   (in_data),
		.out_valid (front_valid),
		.out_ready (!mid_full),
		.out_item  (front_word)
	);

	btc_queue u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_valid),
		.wr_data (front_word),
		.full    (mid_full),
		.pop     (back_ready),
		.rd_data (mid_word),
		.empty   (mid_empty)
	);

	btc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.trim      (trim_q),
		.in_valid  (!mid_empty),
		.in_ready  (back_ready),
		.in_item   (mid_word),
		.out_valid (back_valid),
		.out_ready (oq_ready),
		.out_item  (back_word)
	);

	// Two-entry result queue
	btc_pkg::btc_out_t oq_q [0:1];
	logic       oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_push, oq_pop;

	assign oq_ready = (oq_cnt_q != 2'd2);
	assign oq_push  = back_valid && oq_ready;
	assign empty    = (oq_cnt_q == 2'd0);
	assign oq_pop   = pop && !empty;
	assign out_data = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push)
				oq_wr_q <= !oq_wr_q;
			if (oq_pop)
				oq_rd_q <= !oq_rd_q;
			if (oq_push && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 2'd1;
			else if (!oq_push && oq_pop)
				oq_cnt_q <= oq_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_q[oq_wr_q] <= back_word;
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int DrainCycles = 200;
	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	btc_pkg::btc_in_t in_data;
	logic empty;
	logic pop;
	btc_pkg::btc_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [btc_pkg::CfgIdxW-1:0] cfg_index;
	logic [63:0] cfg_data;

	// Predictor copy of the trim registers
	logic [47:0] trim_t;
	logic [63:0] trim_pa;
	logic [63:0] trim_pb;
	logic [15:0] trim_pc;

	btc_pkg::btc_in_t reading_q[$];
	btc_pkg::btc_out_t compensated_q[$];
	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int cycles;
	bit timed_out;
	logic full_seen;

	barometer_trim_compensation u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Signed 64-bit division truncating toward zero, wrapping on overflow
	function automatic logic [63:0] quot_trunc(logic [63:0] n, logic [63:0] d);
		logic [63:0] an;
		logic [63:0] ad;
		logic [63:0] q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q = an / ad;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	// Compute the compensated word for one reading pair
	function automatic btc_pkg::btc_out_t compensate(btc_pkg::btc_in_t rd);
		btc_pkg::btc_out_t r;
		logic signed [31:0] t1, t2, t3, a, b, tv1, tv2, tf;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, p, ps, w1, w2, pres;
		t1 = {16'd0, trim_t[15:0]};
		t2 = {{16{trim_t[31]}}, trim_t[31:16]};
		t3 = {{16{trim_t[47]}}, trim_t[47:32]};
		a = {15'd0, rd.raw_temperature[19:3]} - (t1 <<< 1);
		tv1 = (a * t2) >>> 11;
		b = {16'd0, rd.raw_temperature[19:4]} - t1;
		tv2 = (((b * b) >>> 12) * t3) >>> 14;
		tf = tv1 + tv2;
		r.fine_temperature = tf;
		r.temperature_centi = (tf * 32'sd5 + 32'sd128) >>> 8;
		p1 = {48'd0, trim_pa[15:0]};
		p2 = {{48{trim_pa[31]}}, trim_pa[31:16]};
		p3 = {{48{trim_pa[47]}}, trim_pa[47:32]};
		p4 = {{48{trim_pa[63]}}, trim_pa[63:48]};
		p5 = {{48{trim_pb[15]}}, trim_pb[15:0]};
		p6 = {{48{trim_pb[31]}}, trim_pb[31:16]};
		p7 = {{48{trim_pb[47]}}, trim_pb[47:32]};
		p8 = {{48{trim_pb[63]}}, trim_pb[63:48]};
		p9 = {{48{trim_pc[15]}}, trim_pc};
		v1 = {{32{tf[31]}}, tf} - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.divide_by_zero = (v1 == 0);
		r.pressure_q24_8 = '0;
		if (v1 != 0) begin
			p = 64'sd1048576 - {44'd0, rd.raw_pressure};
			p = quot_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
			ps = p >>> 13;
			w1 = (p9 * ps * ps) >>> 25;
			w2 = (p8 * p) >>> 19;
			pres = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
			r.pressure_q24_8 = pres[31:0];
		end
		return r;
	endfunction

	// Write one trim register while the block is idle
	task automatic write_trim(logic [btc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			btc_pkg::CFG_TEMP_TRIM:   trim_t = val[47:0];
			btc_pkg::CFG_PRES_TRIM_A: trim_pa = val;
			btc_pkg::CFG_PRES_TRIM_B: trim_pb = val;
			btc_pkg::CFG_PRES_TRIM_C: trim_pc = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (reading_q.size() != 0 || compensated_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Realistic trims give real pressures; random ones hit odd corners
	task automatic load_trims(int kind);
		case (kind)
			0: begin
				write_trim(btc_pkg::CFG_TEMP_TRIM, {16'h0, 16'hFC18, 16'h6A0C, 16'h6E1D});
				write_trim(btc_pkg::CFG_PRES_TRIM_A,
					{16'h1E2C, 16'h0BD0, 16'hD6D0, 16'h8E4A});
				write_trim(btc_pkg::CFG_PRES_TRIM_B,
					{16'hF447, 16'h3C70, 16'hFFF9, 16'h00AC});
				write_trim(btc_pkg::CFG_PRES_TRIM_C, 64'h1770);
			end
			1: begin
				write_trim(btc_pkg::CFG_TEMP_TRIM, 64'hFFFF_FFFF_FFFF_FFFF);
				write_trim(btc_pkg::CFG_PRES_TRIM_A, 64'hFFFF_FFFF_FFFF_FFFF);
				write_trim(btc_pkg::CFG_PRES_TRIM_B, 64'hFFFF_FFFF_FFFF_FFFF);
				write_trim(btc_pkg::CFG_PRES_TRIM_C, 64'hFFFF_FFFF_FFFF_FFFF);
			end
			2: begin
				write_trim(btc_pkg::CFG_TEMP_TRIM, {16'h0, 16'h8000, 16'h7FFF, 16'h8000});
				write_trim(btc_pkg::CFG_PRES_TRIM_A,
					{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000});
				write_trim(btc_pkg::CFG_PRES_TRIM_B,
					{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
				write_trim(btc_pkg::CFG_PRES_TRIM_C, 64'h8000);
			end
			default: begin
				write_trim(btc_pkg::CFG_TEMP_TRIM, {$urandom, $urandom});
				write_trim(btc_pkg::CFG_PRES_TRIM_A, {$urandom, $urandom});
				write_trim(btc_pkg::CFG_PRES_TRIM_B, {$urandom, $urandom});
				write_trim(btc_pkg::CFG_PRES_TRIM_C, {$urandom, $urandom});
			end
		endcase
	endtask

	task automatic queue_reading(logic [19:0] t, logic [19:0] p);
		btc_pkg::btc_in_t rd;
		rd.raw_temperature = t;
		rd.raw_pressure = p;
		reading_q.push_back(rd);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				queue_reading($urandom_range(1) ? 20'hFFFFF : 20'h0, 20'($urandom));
			else
				queue_reading(20'($urandom), 20'($urandom));
		end
	endtask

	// Driver: present the oldest pending reading
	always @(negedge clk) begin
		if (arst_n && push && !full_seen)
			reading_q.pop_front();
		if (reading_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			in_data <= reading_q[0];
		end else begin
			push <= 1'b0;
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Handshake seen at the last rising edge
	always @(posedge clk) full_seen <= full;

	// Monitor: predict at acceptance, compare at pop
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (push && !full)
				compensated_q.push_back(compensate(in_data));
			if (pop && !empty) begin
				if (compensated_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word %h", out_data);
					mismatches <= mismatches + 1;
				end else begin
					if (out_data !== compensated_q[0]) begin
						if (mismatches < 10)
							$display("mismatch: expected %h actual %h", compensated_q[0],
								out_data);
						mismatches <= mismatches + 1;
					end
					compensated_q.pop_front();
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		if (cycles > CycleLimit && !timed_out) begin
			timed_out = 1'b1;
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		trim_t = '0;
		trim_pa = '0;
		trim_pb = '0;
		trim_pc = '0;
		mismatches = 0;
		cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 23;
		recv_idle_pct = 65;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero trims: divisor is zero
		queue_reading(20'h0, 20'h0);
		queue_reading(20'hFFFFF, 20'hFFFFF);
		wait_drained();

		// Directed extremes over realistic and extreme trims
		for (int k = 0; k < 3; k++) begin
			load_trims(k);
			queue_reading(20'h0, 20'h0);
			queue_reading(20'hFFFFF, 20'hFFFFF);
			queue_reading(20'h0, 20'hFFFFF);
			queue_reading(20'hFFFFF, 20'h0);
			queue_reading(20'h7E6C0, 20'h65A40);
			queue_reading(20'h80000, 20'h80000);
			wait_drained();
		end

		// Random phases with changing trims and idle profiles
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 65;
				recv_idle_pct = 23;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_trims(ph % 3 == 0 ? 0 : 3);
			// In realistic-trim phases, mostly near the realistic operating point
			for (int i = 0; i < 150; i++) begin
				if (ph % 3 == 0 && $urandom_range(3) != 0)
					queue_reading(20'(20'h70000 + $urandom_range(20'h1FFFF)),
						20'(20'h50000 + $urandom_range(20'h2FFFF)));
				else
					queue_random(1);
			end
			wait_drained();
		end

		if (mismatches == 0 && compensated_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
